// ===== design/abld_pkg.sv =====
// abld_pkg: shared constants, codes and structs for the analog button ladder decoder.
// No dependencies; used by every design file and by the checker.
package abld_pkg;

    // Sizing
    localparam int unsigned MAX_BUTTONS = 4;
    localparam int unsigned ADC_BITS    = 10;
    localparam int unsigned LEVEL_REGS  = 4;

    localparam int unsigned ADC_W      = 10;
    localparam int unsigned TIME_W     = 16;
    localparam int unsigned THR_W      = 10;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned BTN_W      = 2;
    localparam int unsigned DBC_W      = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    // Sample mask when the converter is narrower than the field
    localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((64'd1 << ADC_BITS) - 64'd1);

    // Number of usable buttons
    localparam int unsigned LIMIT_MAX = (MAX_BUTTONS < LEVEL_REGS) ? MAX_BUTTONS : LEVEL_REGS;
    localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'(LIMIT_MAX);

    // Timing rules, in ms
    localparam logic [TIME_W-1:0] IDLE_PERIOD   = TIME_W'(20);
    localparam logic [TIME_W-1:0] BOUNCE_PERIOD = TIME_W'(5);
    localparam logic [TIME_W-1:0] REPRESS_GUARD = TIME_W'(50);
    localparam logic [TIME_W-1:0] SWITCH_WINDOW = TIME_W'(300);
    localparam logic [DBC_W-1:0]  BOUNCE_SAMPLES = DBC_W'(3);

    // Register reset values
    localparam logic [THR_W-1:0] THR_RESET   = THR_W'(50);
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4);

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOWN = 2'd1,
        EV_HOLD = 2'd2,
        EV_UP   = 2'd3
    } event_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_COUNT     = 3'd1,
        REG_LEVEL0    = 3'd2,
        REG_LEVEL1    = 3'd3,
        REG_LEVEL2    = 3'd4,
        REG_LEVEL3    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [THR_W-1:0]                  threshold;
        logic [CNT_W-1:0]                  limit;
        logic [LEVEL_REGS-1:0][ADC_W-1:0]  levels;
    } cfg_t;

    typedef struct packed {
        logic               pressed;
        logic [DBC_W-1:0]   dbc;
        logic [TIME_W-1:0]  last_sample_time;
        logic [ADC_W-1:0]   last_level;
        logic [TIME_W-1:0]  release_time;
        logic [TIME_W-1:0]  press_time;
        logic [BTN_W-1:0]   active;
        logic               muted;
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic [ADC_W-1:0]   adc_sample;
        logic               adc_ready;
        logic               suppress_release;
    } poll_t;

    typedef struct packed {
        event_kind_t        kind;
        logic [BTN_W-1:0]   button_id;
        logic [TIME_W-1:0]  elapsed;
        logic               pressed_now;
        logic               pressed_before;
    } result_t;

endpackage

// ===== design/analog_button_ladder_decoder_top.sv =====
// analog_button_ladder_decoder_top: top level; input register, decoder state, result register.
// Depends on abld_pkg, abld_cfg and abld_step.
//
// Decodes a resistor-ladder button line from periodic polls. Each poll word
// (time in ms, ADC sample, ready flag, release-suppress flag) yields exactly one
// result word: event kind (none/down/hold/up), button id, elapsed ms and the
// pressed flags. The block takes one poll word per clock while in_stall is
// low. The poll word is captured in an input register; its result word is
// held in the result register, which drives the outputs. The whole decision
// (timing check, debounce, four parallel level windows with a priority pick,
// re-press guard and switch window) runs in one combinational pass against the
// decoder state. The result lands in the output register on the same edge that
// updates the state, so the next word already sees it.
// in_stall rises only while the output register holds an unaccepted word and
// out_stall is high. Configuration registers (index 0 threshold, 1 button
// count, 2..5 levels) are written with cfg_we and take effect at once; write
// them only while no word is in flight. Sampling runs every 20 ms idle and
// every 5 ms while a three-sample debounce is in progress.
module analog_button_ladder_decoder_top (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [abld_pkg::TIME_W-1:0]      now_ms,
    input  logic [abld_pkg::ADC_W-1:0]       adc_sample,
    input  logic                             adc_ready,
    input  logic                             suppress_release,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       event_kind,
    output logic [abld_pkg::BTN_W-1:0]       button_id,
    output logic [abld_pkg::TIME_W-1:0]      elapsed_ms,
    output logic                             pressed_now,
    output logic                             pressed_before,

    input  logic                             cfg_we,
    input  logic [abld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [abld_pkg::CFG_DATA_W-1:0]  cfg_data
);

    abld_pkg::cfg_t     cfg;
    abld_pkg::poll_t    poll_reg;
    logic               poll_valid_reg;
    abld_pkg::state_t   state_reg;
    abld_pkg::state_t   state_next;
    abld_pkg::result_t  res_next;
    abld_pkg::result_t  res_reg;
    logic               res_valid_reg;
    logic               out_free;
    logic               advance;
    logic               in_take;

    abld_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    abld_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .poll (poll_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // result slot frees when empty or being taken this cycle
    assign out_free = !res_valid_reg || !out_stall;
    assign advance  = poll_valid_reg && out_free;
    assign in_stall = poll_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            poll_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            poll_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            poll_reg.now_ms           <= now_ms;
            poll_reg.adc_sample       <= adc_sample;
            poll_reg.adc_ready        <= adc_ready;
            poll_reg.suppress_release <= suppress_release;
        end
    end

    // decoder state moves together with the word it processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = res_valid_reg;
    assign event_kind     = res_reg.kind;
    assign button_id      = res_reg.button_id;
    assign elapsed_ms     = res_reg.elapsed;
    assign pressed_now    = res_reg.pressed_now;
    assign pressed_before = res_reg.pressed_before;

endmodule

// ===== design/abld_cfg.sv =====
// abld_cfg: configuration register file (threshold, button count, four levels).
// Depends on abld_pkg.
module abld_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [abld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [abld_pkg::CFG_DATA_W-1:0]  cfg_data,
    output abld_pkg::cfg_t                   cfg
);

    logic [abld_pkg::THR_W-1:0]                                  thr_reg;
    logic [abld_pkg::CNT_W-1:0]                                  count_reg;
    logic [abld_pkg::LEVEL_REGS-1:0][abld_pkg::ADC_W-1:0]        levels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= abld_pkg::THR_RESET;
            count_reg  <= abld_pkg::COUNT_RESET;
            levels_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                abld_pkg::REG_THRESHOLD: thr_reg       <= cfg_data[abld_pkg::THR_W-1:0];
                abld_pkg::REG_COUNT:     count_reg     <= cfg_data[abld_pkg::CNT_W-1:0];
                abld_pkg::REG_LEVEL0:    levels_reg[0] <= cfg_data[abld_pkg::ADC_W-1:0];
                abld_pkg::REG_LEVEL1:    levels_reg[1] <= cfg_data[abld_pkg::ADC_W-1:0];
                abld_pkg::REG_LEVEL2:    levels_reg[2] <= cfg_data[abld_pkg::ADC_W-1:0];
                abld_pkg::REG_LEVEL3:    levels_reg[3] <= cfg_data[abld_pkg::ADC_W-1:0];
                default:                 ;
            endcase
        end
    end

    // clamp count to the buttons actually built
    assign cfg.threshold = thr_reg;
    assign cfg.limit     = (count_reg > abld_pkg::LIMIT_CAP) ? abld_pkg::LIMIT_CAP : count_reg;
    assign cfg.levels    = levels_reg;

endmodule

// ===== design/abld_step.sv =====
// abld_step: one poll's decision logic: sample timing, debounce, level match, events.
// Purely combinational; depends on abld_pkg.
module abld_step (
    input  abld_pkg::cfg_t     cfg,
    input  abld_pkg::state_t   cur,
    input  abld_pkg::poll_t    poll,
    output abld_pkg::state_t   nxt,
    output abld_pkg::result_t  res
);

    logic [abld_pkg::TIME_W-1:0]  since_sample;
    logic [abld_pkg::TIME_W-1:0]  since_release;
    logic [abld_pkg::TIME_W-1:0]  since_press;
    logic                         too_early;
    logic                         take;
    logic [abld_pkg::ADC_W-1:0]   smp;
    logic [abld_pkg::ADC_W-1:0]   adiff;
    logic                         jump;
    logic [abld_pkg::DBC_W-1:0]   dbc_eff;
    logic [abld_pkg::LEVEL_REGS-1:0] near;
    logic                         found;
    logic [abld_pkg::BTN_W-1:0]   hit_idx;

    assign since_sample  = poll.now_ms - cur.last_sample_time;
    assign since_release = poll.now_ms - cur.release_time;
    assign since_press   = poll.now_ms - cur.press_time;
    assign too_early     = (cur.dbc == '0) ? (since_sample < abld_pkg::IDLE_PERIOD)
                                           : (since_sample < abld_pkg::BOUNCE_PERIOD);
    assign take          = !too_early && poll.adc_ready;
    assign smp           = poll.adc_sample & abld_pkg::ADC_MASK;

    assign adiff   = (smp >= cur.last_level) ? (smp - cur.last_level) : (cur.last_level - smp);
    assign jump    = adiff > cfg.threshold;
    assign dbc_eff = jump ? abld_pkg::DBC_W'(1) : cur.dbc;

    // window test per level, strict on both sides, no wrap
    always_comb
    begin
        for (int n = 0; n < abld_pkg::LEVEL_REGS; n++)
        begin
            near[n] = ({1'b0, smp} < ({1'b0, cfg.levels[n]} + {1'b0, cfg.threshold}))
                   && (({1'b0, smp} + {1'b0, cfg.threshold}) > {1'b0, cfg.levels[n]})
                   && (abld_pkg::CNT_W'(n) < cfg.limit);
        end
    end

    // lowest index wins
    always_comb
    begin
        found   = 1'b0;
        hit_idx = '0;
        for (int n = abld_pkg::LEVEL_REGS - 1; n >= 0; n--)
        begin
            if (near[n])
            begin
                found   = 1'b1;
                hit_idx = abld_pkg::BTN_W'(n);
            end
        end
    end

    always_comb
    begin
        nxt                = cur;
        nxt.muted          = cur.muted | poll.suppress_release;
        res.kind           = abld_pkg::EV_NONE;
        res.elapsed        = '0;
        res.pressed_before = cur.pressed;

        if (take)
        begin
            nxt.last_sample_time = poll.now_ms;
            nxt.last_level       = smp;
            if (dbc_eff < abld_pkg::BOUNCE_SAMPLES)
            begin
                nxt.dbc = dbc_eff + abld_pkg::DBC_W'(1);
            end
            else
            begin
                nxt.dbc = '0;
                if (found)
                begin
                    if (since_release >= abld_pkg::REPRESS_GUARD)
                    begin
                        if (((cur.active != hit_idx) && (since_press < abld_pkg::SWITCH_WINDOW))
                            || !cur.pressed)
                        begin
                            nxt.active     = hit_idx;
                            nxt.pressed    = 1'b1;
                            nxt.press_time = poll.now_ms;
                            res.kind       = abld_pkg::EV_DOWN;
                            res.elapsed    = since_release;
                        end
                        else
                        begin
                            res.kind    = abld_pkg::EV_HOLD;
                            res.elapsed = since_press;
                        end
                    end
                end
                else if (cur.pressed)
                begin
                    nxt.pressed      = 1'b0;
                    nxt.release_time = poll.now_ms;
                    if (nxt.muted)
                    begin
                        // one-shot mute eats this release
                        res.pressed_before = 1'b0;
                        nxt.muted          = 1'b0;
                    end
                    else
                    begin
                        res.kind    = abld_pkg::EV_UP;
                        res.elapsed = since_press;
                    end
                end
            end
        end

        res.button_id   = nxt.active;
        res.pressed_now = nxt.pressed;
    end

endmodule

// ===== design/abld_checker.sv =====
// abld_checker: port-level assertions for the decoder, bound to the top level.
// Depends on abld_pkg and analog_button_ladder_decoder_top.
module abld_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [1:0]                    event_kind,
    input  logic [abld_pkg::TIME_W-1:0]   elapsed_ms,
    input  logic                          pressed_now,
    input  logic                          pressed_before
);

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(elapsed_ms))
        else $error("stalled result word changed");

    // no event carries no elapsed time
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == abld_pkg::EV_NONE) |-> (elapsed_ms == '0))
        else $error("elapsed time on a word with no event");

    // a down leaves the button pressed
    a_down: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == abld_pkg::EV_DOWN) |-> pressed_now)
        else $error("down event without pressed state");

    // a hold needs a press before and after
    a_hold_ev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == abld_pkg::EV_HOLD) |-> pressed_now && pressed_before)
        else $error("hold event outside a press");

    // an up ends a press
    a_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == abld_pkg::EV_UP) |-> !pressed_now && pressed_before)
        else $error("up event without a prior press");

endmodule

bind analog_button_ladder_decoder_top abld_checker u_abld_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_kind     (event_kind),
    .elapsed_ms     (elapsed_ms),
    .pressed_now    (pressed_now),
    .pressed_before (pressed_before)
);
